>>> hw/rtl/nlq_pkg.sv
package nlq_pkg;

  // Table size that the top level uses unless told otherwise.
  localparam int TABLE_ENTRIES_DEF = 16;

  localparam int ADDR_W   = 16;
  localparam int SAMPLE_W = 8;
  localparam int COUNT_W  = 8;
  localparam int TIME_W   = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  // All three windows come out of reset at sixteen.
  localparam logic [COUNT_W-1:0] WINDOW_RESET = COUNT_W'(16);

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_PACKET_WINDOW = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_RSSI_WINDOW   = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_LQI_WINDOW    = CFG_IDX_W'(2);

  // One neighbour record as it sits in the table memory.
  typedef struct packed {
    logic [ADDR_W-1:0]   addr;
    logic [SAMPLE_W-1:0] rssi_avg;
    logic [SAMPLE_W-1:0] lqi_avg;
    logic [COUNT_W-1:0]  pkt_cnt;
    logic [COUNT_W-1:0]  rssi_cnt;
    logic [COUNT_W-1:0]  lqi_cnt;
    logic [TIME_W-1:0]   heard_time;
  } entry_t;

  // Request to the shared divider.
  typedef struct packed {
    logic                start;
    logic [SAMPLE_W-1:0] dividend;
    logic [COUNT_W-1:0]  divisor;
  } div_req_t;

endpackage

>>> hw/rtl/nlq_ram.sv
module nlq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hw/rtl/nlq_div.sv
module nlq_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  nlq_pkg::div_req_t             req,
  output logic                          done,
  output logic [nlq_pkg::SAMPLE_W-1:0]  quotient
);

  localparam int STEPS = nlq_pkg::SAMPLE_W;
  localparam int CW    = $clog2(STEPS);

  logic                         busy_r;
  logic                         done_r;
  logic [CW-1:0]                cnt_r;
  logic [nlq_pkg::SAMPLE_W-1:0] quo_r;
  logic [nlq_pkg::SAMPLE_W-1:0] rem_r;
  logic [nlq_pkg::COUNT_W-1:0]  dvs_r;
  logic [nlq_pkg::SAMPLE_W:0]   trial;
  logic                         ge;

  // Restoring division: one quotient bit per cycle, most significant first.
  assign trial = {rem_r, quo_r[nlq_pkg::SAMPLE_W-1]};
  assign ge    = trial >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == CW'(STEPS - 1));
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(STEPS - 1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  // Remainder and quotient shift register.
  always_ff @(posedge clk) begin
    if (req.start) begin
      quo_r <= req.dividend;
      rem_r <= '0;
      dvs_r <= req.divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[nlq_pkg::SAMPLE_W-2:0], ge};
      rem_r <= ge ? nlq_pkg::SAMPLE_W'(trial - {1'b0, dvs_r})
                  : trial[nlq_pkg::SAMPLE_W-1:0];
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

>>> hw/rtl/neighbor_link_quality_table.sv
// busy stays high from a taken start until its result is strobed, and one item is taken at a time.
// The time an item takes is set by the table scan (one memory read a cycle) and by the shared
// 8-step divider, used for a known neighbour once for the RSSI average and once for the LQI
// average, each unless that count has already reached its window.
// Reset clears all entries at once (valid flags) and sets every window to 16.
// Results are strobed for one cycle on out_valid; the receiver cannot stall.
module neighbor_link_quality_table #(
  parameter int TABLE_ENTRIES = nlq_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [nlq_pkg::ADDR_W-1:0]      in_sender_address,
  input  logic [nlq_pkg::SAMPLE_W-1:0]    in_rssi_sample,
  input  logic [nlq_pkg::SAMPLE_W-1:0]    in_lqi_sample,
  input  logic [nlq_pkg::TIME_W-1:0]      in_arrival_time,
  output logic                            out_valid,
  output logic [nlq_pkg::ADDR_W-1:0]      out_neighbor_address,
  output logic [nlq_pkg::SAMPLE_W-1:0]    out_rssi_average,
  output logic [nlq_pkg::SAMPLE_W-1:0]    out_lqi_average,
  output logic [nlq_pkg::COUNT_W-1:0]     out_packet_count,
  output logic                            out_was_known,
  output logic                            out_did_evict,
  output logic [nlq_pkg::ADDR_W-1:0]      out_evicted_address,
  input  logic                            cfg_we,
  input  logic [nlq_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [nlq_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int IW = $clog2(TABLE_ENTRIES);
  localparam int EW = $bits(nlq_pkg::entry_t);

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_LAST, S_DECIDE, S_R_START, S_R_WAIT, S_L_START, S_L_WAIT, S_WRITE
  } state_t;

  // Control state.
  state_t                      state_r, state_nxt;
  logic                        chk_vld_r, chk_vld_nxt;
  logic [TABLE_ENTRIES-1:0]    valid_r, valid_nxt;
  logic [nlq_pkg::COUNT_W-1:0] pkt_win_r, pkt_win_nxt;
  logic [nlq_pkg::COUNT_W-1:0] rssi_win_r, rssi_win_nxt;
  logic [nlq_pkg::COUNT_W-1:0] lqi_win_r, lqi_win_nxt;
  logic                        out_valid_r;

  // Item payload and scan results.
  logic [nlq_pkg::ADDR_W-1:0]   in_addr_r;
  logic [nlq_pkg::SAMPLE_W-1:0] in_rssi_r;
  logic [nlq_pkg::SAMPLE_W-1:0] in_lqi_r;
  logic [nlq_pkg::TIME_W-1:0]   in_time_r;
  logic [IW-1:0]                idx_r;
  logic [IW-1:0]                chk_idx_r;
  logic                         found_r;
  nlq_pkg::entry_t              hit_r;
  logic                         free_found_r;
  logic [IW-1:0]                free_slot_r;
  logic                         old_vld_r;
  logic [IW-1:0]                old_slot_r;
  logic [nlq_pkg::TIME_W-1:0]   old_last_r;
  logic [nlq_pkg::ADDR_W-1:0]   old_addr_r;
  logic [IW-1:0]                slot_r;
  logic                         evict_r;
  logic [nlq_pkg::COUNT_W-1:0]  pkt_new_r;
  logic [nlq_pkg::COUNT_W-1:0]  rc_new_r;
  logic [nlq_pkg::COUNT_W-1:0]  lc_new_r;
  logic                         r_restart_r;
  logic                         l_restart_r;
  logic [nlq_pkg::SAMPLE_W-1:0] rssi_new_r;
  logic [nlq_pkg::SAMPLE_W-1:0] lqi_new_r;
  logic                         neg_r;

  // Output registers.
  logic [nlq_pkg::ADDR_W-1:0]   out_addr_r;
  logic [nlq_pkg::SAMPLE_W-1:0] out_rssi_r;
  logic [nlq_pkg::SAMPLE_W-1:0] out_lqi_r;
  logic [nlq_pkg::COUNT_W-1:0]  out_pkt_r;
  logic                         out_known_r;
  logic                         out_evict_r;
  logic [nlq_pkg::ADDR_W-1:0]   out_ev_addr_r;

  logic                         accept;
  logic                         ram_we;
  nlq_pkg::entry_t              ram_wdata;
  logic [EW-1:0]                ram_rdata;
  nlq_pkg::entry_t              rd_entry;
  logic                         chk_valid;
  nlq_pkg::div_req_t            div_req;
  logic                         div_done;
  logic [nlq_pkg::SAMPLE_W-1:0] div_q;
  logic [nlq_pkg::SAMPLE_W-1:0] d_sample;
  logic [nlq_pkg::SAMPLE_W-1:0] d_avg;
  logic                         d_neg;
  logic [nlq_pkg::SAMPLE_W-1:0] q_applied;

  assign accept   = start && (state_r == S_IDLE);
  assign busy     = (state_r != S_IDLE);
  assign rd_entry = nlq_pkg::entry_t'(ram_rdata);
  assign chk_valid = valid_r[chk_idx_r];

  // Neighbour table memory.
  assign ram_we    = (state_r == S_WRITE);
  assign ram_wdata = '{addr: in_addr_r, rssi_avg: rssi_new_r, lqi_avg: lqi_new_r,
                       pkt_cnt: pkt_new_r, rssi_cnt: rc_new_r, lqi_cnt: lc_new_r,
                       heard_time: in_time_r};

  nlq_ram #(.WIDTH(EW), .DEPTH(TABLE_ENTRIES)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (slot_r),
    .wdata (ram_wdata),
    .raddr (idx_r),
    .rdata (ram_rdata)
  );

  // Difference between the sample and the stored average, as sign and magnitude.
  assign d_sample = (state_r == S_L_START) ? in_lqi_r : in_rssi_r;
  assign d_avg    = (state_r == S_L_START) ? hit_r.lqi_avg : hit_r.rssi_avg;
  assign d_neg    = d_sample < d_avg;

  always_comb begin
    div_req.dividend = d_neg ? (d_avg - d_sample) : (d_sample - d_avg);
    div_req.divisor  = (state_r == S_L_START) ? lc_new_r : rc_new_r;
    div_req.start    = ((state_r == S_R_START) && !r_restart_r) ||
                       ((state_r == S_L_START) && !l_restart_r);
  end

  nlq_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (div_req),
    .done     (div_done),
    .quotient (div_q)
  );

  // The new average always lies between the old one and the sample.
  assign q_applied = (state_r == S_L_WAIT)
                   ? (neg_r ? hit_r.lqi_avg - div_q : hit_r.lqi_avg + div_q)
                   : (neg_r ? hit_r.rssi_avg - div_q : hit_r.rssi_avg + div_q);

  // Sequencer and configuration next state.
  always_comb begin
    state_nxt    = state_r;
    chk_vld_nxt  = chk_vld_r;
    valid_nxt    = valid_r;
    pkt_win_nxt  = pkt_win_r;
    rssi_win_nxt = rssi_win_r;
    lqi_win_nxt  = lqi_win_r;

    if (cfg_we) begin
      unique case (cfg_index)
        nlq_pkg::CFG_PACKET_WINDOW: pkt_win_nxt  = cfg_data;
        nlq_pkg::CFG_RSSI_WINDOW:   rssi_win_nxt = cfg_data;
        nlq_pkg::CFG_LQI_WINDOW:    lqi_win_nxt  = cfg_data;
        default: ;
      endcase
    end

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt   = S_SCAN;
          chk_vld_nxt = 1'b0;
        end
      end
      S_SCAN: begin
        chk_vld_nxt = 1'b1;
        if (idx_r == IW'(TABLE_ENTRIES - 1)) begin
          state_nxt = S_LAST;
        end
      end
      S_LAST:    state_nxt = S_DECIDE;
      S_DECIDE:  state_nxt = found_r ? S_R_START : S_WRITE;
      S_R_START: state_nxt = r_restart_r ? S_L_START : S_R_WAIT;
      S_R_WAIT: begin
        if (div_done) begin
          state_nxt = S_L_START;
        end
      end
      S_L_START: state_nxt = l_restart_r ? S_WRITE : S_L_WAIT;
      S_L_WAIT: begin
        if (div_done) begin
          state_nxt = S_WRITE;
        end
      end
      S_WRITE: begin
        state_nxt          = S_IDLE;
        valid_nxt[slot_r]  = 1'b1;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State, valid flags, windows and the result strobe and fields.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      chk_vld_r     <= 1'b0;
      valid_r       <= '0;
      pkt_win_r     <= nlq_pkg::WINDOW_RESET;
      rssi_win_r    <= nlq_pkg::WINDOW_RESET;
      lqi_win_r     <= nlq_pkg::WINDOW_RESET;
      out_valid_r   <= 1'b0;
      out_addr_r    <= '0;
      out_rssi_r    <= '0;
      out_lqi_r     <= '0;
      out_pkt_r     <= '0;
      out_known_r   <= 1'b0;
      out_evict_r   <= 1'b0;
      out_ev_addr_r <= '0;
    end else begin
      state_r     <= state_nxt;
      chk_vld_r   <= chk_vld_nxt;
      valid_r     <= valid_nxt;
      pkt_win_r   <= pkt_win_nxt;
      rssi_win_r  <= rssi_win_nxt;
      lqi_win_r   <= lqi_win_nxt;
      out_valid_r <= (state_r == S_WRITE);
      if (state_r == S_WRITE) begin
        out_addr_r    <= in_addr_r;
        out_rssi_r    <= rssi_new_r;
        out_lqi_r     <= lqi_new_r;
        out_pkt_r     <= pkt_new_r;
        out_known_r   <= found_r;
        out_evict_r   <= evict_r;
        out_ev_addr_r <= evict_r ? old_addr_r : '0;
      end
    end
  end

  // Datapath: scan bookkeeping, count updates and averages.
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        in_addr_r    <= in_sender_address;
        in_rssi_r    <= in_rssi_sample;
        in_lqi_r     <= in_lqi_sample;
        in_time_r    <= in_arrival_time;
        idx_r        <= '0;
        found_r      <= 1'b0;
        free_found_r <= 1'b0;
        old_vld_r    <= 1'b0;
      end
      S_SCAN, S_LAST: begin
        if (state_r == S_SCAN) begin
          chk_idx_r <= idx_r;
          if (idx_r != IW'(TABLE_ENTRIES - 1)) begin
            idx_r <= idx_r + 1'b1;
          end
        end
        // Check the entry read in the previous cycle.
        if (chk_vld_r || state_r == S_LAST) begin
          if (chk_valid && rd_entry.addr == in_addr_r && !found_r) begin
            found_r <= 1'b1;
            slot_r  <= chk_idx_r;
            hit_r   <= rd_entry;
          end
          if (!chk_valid && !free_found_r) begin
            free_found_r <= 1'b1;
            free_slot_r  <= chk_idx_r;
          end
          if (chk_valid && (!old_vld_r || rd_entry.heard_time < old_last_r)) begin
            old_vld_r  <= 1'b1;
            old_slot_r <= chk_idx_r;
            old_last_r <= rd_entry.heard_time;
            old_addr_r <= rd_entry.addr;
          end
        end
      end
      S_DECIDE: begin
        if (found_r) begin
          evict_r     <= 1'b0;
          pkt_new_r   <= (hit_r.pkt_cnt >= pkt_win_r) ? 8'd1 : hit_r.pkt_cnt + 8'd1;
          r_restart_r <= hit_r.rssi_cnt >= rssi_win_r;
          l_restart_r <= hit_r.lqi_cnt >= lqi_win_r;
          rc_new_r    <= (hit_r.rssi_cnt >= rssi_win_r) ? 8'd1 : hit_r.rssi_cnt + 8'd1;
          lc_new_r    <= (hit_r.lqi_cnt >= lqi_win_r) ? 8'd1 : hit_r.lqi_cnt + 8'd1;
        end else begin
          // New neighbour: a free slot if any, otherwise the oldest entry goes.
          slot_r     <= free_found_r ? free_slot_r : old_slot_r;
          evict_r    <= !free_found_r;
          pkt_new_r  <= 8'd1;
          rc_new_r   <= 8'd1;
          lc_new_r   <= 8'd1;
          rssi_new_r <= in_rssi_r;
          lqi_new_r  <= in_lqi_r;
        end
      end
      S_R_START: begin
        neg_r <= d_neg;
        if (r_restart_r) begin
          rssi_new_r <= in_rssi_r;
        end
      end
      S_R_WAIT: begin
        if (div_done) begin
          rssi_new_r <= q_applied;
        end
      end
      S_L_START: begin
        neg_r <= d_neg;
        if (l_restart_r) begin
          lqi_new_r <= in_lqi_r;
        end
      end
      S_L_WAIT: begin
        if (div_done) begin
          lqi_new_r <= q_applied;
        end
      end
      S_WRITE: ;
      default: ;
    endcase
  end

  assign out_valid            = out_valid_r;
  assign out_neighbor_address = out_addr_r;
  assign out_rssi_average     = out_rssi_r;
  assign out_lqi_average      = out_lqi_r;
  assign out_packet_count     = out_pkt_r;
  assign out_was_known        = out_known_r;
  assign out_did_evict        = out_evict_r;
  assign out_evicted_address  = out_ev_addr_r;

  // Taking an item makes the block busy, with no result strobed yet.
  assert property (@(posedge clk) disable iff (!rst_n) accept |=> busy && !out_valid)
    else $error("block not busy after taking an item");

  // Each result is a single-cycle strobe that ends the item.
  assert property (@(posedge clk) disable iff (!rst_n) out_valid |-> !busy ##1 !out_valid)
    else $error("result strobe longer than one cycle");

  // A newly inserted neighbour starts with a packet count of one.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_was_known |-> out_packet_count == 8'd1)
    else $error("new neighbour with packet count other than one");

  // Eviction only for new neighbours, and no evicted address without one.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!out_did_evict || !out_was_known) &&
                  (out_did_evict || out_evicted_address == '0))
    else $error("inconsistent eviction report");

endmodule

>>> tb/neighbor_link_quality_table_tb.sv
`timescale 1ns / 100ps

module neighbor_link_quality_table_tb;

  localparam int TABLE_ENTRIES = nlq_pkg::TABLE_ENTRIES_DEF;
  localparam int ADDR_W     = nlq_pkg::ADDR_W;
  localparam int SAMPLE_W   = nlq_pkg::SAMPLE_W;
  localparam int COUNT_W    = nlq_pkg::COUNT_W;
  localparam int TIME_W     = nlq_pkg::TIME_W;
  localparam int CFG_IDX_W  = nlq_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W = nlq_pkg::CFG_DATA_W;
  localparam int POOL_SIZE = 24;
  localparam int DIRECTED_ROWS = 24;
  // Index 3 is not a register; writes to it must change nothing.
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_INDEX = CFG_IDX_W'(3);

  // One result of the block, as it appears on the out_ ports.
  typedef struct packed {
    logic [ADDR_W-1:0]   addr;
    logic [SAMPLE_W-1:0] rssi;
    logic [SAMPLE_W-1:0] lqi;
    logic [COUNT_W-1:0]  pkt_count;
    logic                known;
    logic                evicted;
    logic [ADDR_W-1:0]   evicted_addr;
  } nbr_update_t;

  // One row of directed stimulus; want is used only where pinned is set.
  typedef struct packed {
    logic [ADDR_W-1:0]   addr;
    logic [SAMPLE_W-1:0] rssi;
    logic [SAMPLE_W-1:0] lqi;
    logic [TIME_W-1:0]   arrival;
    logic                pinned;
    nbr_update_t         want;
  } packet_row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  logic [ADDR_W-1:0]     in_sender_address;
  logic [SAMPLE_W-1:0]   in_rssi_sample;
  logic [SAMPLE_W-1:0]   in_lqi_sample;
  logic [TIME_W-1:0]     in_arrival_time;
  logic                  out_valid;
  logic [ADDR_W-1:0]     out_neighbor_address;
  logic [SAMPLE_W-1:0]   out_rssi_average;
  logic [SAMPLE_W-1:0]   out_lqi_average;
  logic [COUNT_W-1:0]    out_packet_count;
  logic                  out_was_known;
  logic                  out_did_evict;
  logic [ADDR_W-1:0]     out_evicted_address;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // Shadow copy of the windows and of the neighbour table.
  logic [COUNT_W-1:0]  pkt_win;
  logic [COUNT_W-1:0]  rssi_win;
  logic [COUNT_W-1:0]  lqi_win;
  logic                nbr_valid    [TABLE_ENTRIES];
  logic [ADDR_W-1:0]   nbr_addr     [TABLE_ENTRIES];
  logic [SAMPLE_W-1:0] nbr_rssi_avg [TABLE_ENTRIES];
  logic [SAMPLE_W-1:0] nbr_lqi_avg  [TABLE_ENTRIES];
  logic [COUNT_W-1:0]  nbr_pkt_cnt  [TABLE_ENTRIES];
  logic [COUNT_W-1:0]  nbr_rssi_cnt [TABLE_ENTRIES];
  logic [COUNT_W-1:0]  nbr_lqi_cnt  [TABLE_ENTRIES];
  logic [TIME_W-1:0]   nbr_heard    [TABLE_ENTRIES];

  nbr_update_t         pending_updates[$];
  int                  fail_count = 0;

  // Addresses that the random part draws from, and the one it favours.
  logic [ADDR_W-1:0]   addr_pool [POOL_SIZE];
  logic [ADDR_W-1:0]   hot_addr;
  bit                  hot_on;
  logic [TIME_W-1:0]   tick;

  // Directed rows, run with the reset windows of sixteen. The table is filled,
  // then the oldest entries are evicted, including on a tie for the oldest time.
  packet_row_t directed_rows [DIRECTED_ROWS] = '{
    '{16'h0000, 8'h00, 8'h00, 32'h0000_0000, 1'b1,
      '{16'h0000, 8'h00, 8'h00, 8'd1, 1'b0, 1'b0, 16'h0000}},
    '{16'hFFFF, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 1'b1,
      '{16'hFFFF, 8'hFF, 8'hFF, 8'd1, 1'b0, 1'b0, 16'h0000}},
    '{16'h0000, 8'hFF, 8'hFF, 32'd5, 1'b1,
      '{16'h0000, 8'd127, 8'd127, 8'd2, 1'b1, 1'b0, 16'h0000}},
    '{16'hFFFF, 8'h00, 8'h00, 32'd6, 1'b1,
      '{16'hFFFF, 8'd128, 8'd128, 8'd2, 1'b1, 1'b0, 16'h0000}},
    '{16'h1001, 8'h01, 8'hFE, 32'd10, 1'b0, '0},
    '{16'h1002, 8'h12, 8'hED, 32'd11, 1'b0, '0},
    '{16'h1003, 8'h23, 8'hDC, 32'd12, 1'b0, '0},
    '{16'h1004, 8'h34, 8'hCB, 32'd13, 1'b0, '0},
    '{16'h1005, 8'h45, 8'hBA, 32'd14, 1'b0, '0},
    '{16'h1006, 8'h56, 8'hA9, 32'd15, 1'b0, '0},
    '{16'h1007, 8'h67, 8'h98, 32'd16, 1'b0, '0},
    '{16'h1008, 8'h78, 8'h87, 32'd17, 1'b0, '0},
    '{16'h1009, 8'h89, 8'h76, 32'd18, 1'b0, '0},
    '{16'h100A, 8'h9A, 8'h65, 32'd19, 1'b0, '0},
    '{16'h100B, 8'hAB, 8'h54, 32'd20, 1'b0, '0},
    '{16'h100C, 8'hBC, 8'h43, 32'd21, 1'b0, '0},
    '{16'h100D, 8'hCD, 8'h32, 32'd22, 1'b0, '0},
    '{16'h100E, 8'hDE, 8'h21, 32'd23, 1'b0, '0},
    '{16'hABCD, 8'h40, 8'h80, 32'd30, 1'b1,
      '{16'hABCD, 8'h40, 8'h80, 8'd1, 1'b0, 1'b1, 16'h0000}},
    '{16'h5555, 8'hAA, 8'h55, 32'd31, 1'b1,
      '{16'h5555, 8'hAA, 8'h55, 8'd1, 1'b0, 1'b1, 16'hFFFF}},
    '{16'h1001, 8'h30, 8'h30, 32'd11, 1'b0, '0},
    '{16'h7777, 8'h01, 8'h02, 32'd40, 1'b1,
      '{16'h7777, 8'h01, 8'h02, 8'd1, 1'b0, 1'b1, 16'h1001}},
    '{16'h8888, 8'hFE, 8'hFD, 32'd41, 1'b1,
      '{16'h8888, 8'hFE, 8'hFD, 8'd1, 1'b0, 1'b1, 16'h1002}},
    '{16'hABCD, 8'h00, 8'hFF, 32'd42, 1'b0, '0}
  };

  neighbor_link_quality_table #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_sender_address   (in_sender_address),
    .in_rssi_sample      (in_rssi_sample),
    .in_lqi_sample       (in_lqi_sample),
    .in_arrival_time     (in_arrival_time),
    .out_valid           (out_valid),
    .out_neighbor_address(out_neighbor_address),
    .out_rssi_average    (out_rssi_average),
    .out_lqi_average     (out_lqi_average),
    .out_packet_count    (out_packet_count),
    .out_was_known       (out_was_known),
    .out_did_evict       (out_did_evict),
    .out_evicted_address (out_evicted_address),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // A running average step; the division truncates toward zero.
  function automatic logic [SAMPLE_W-1:0] average_step(input logic [SAMPLE_W-1:0] avg,
                                                       input logic [SAMPLE_W-1:0] sample,
                                                       input logic [COUNT_W-1:0] cnt);
    int delta;
    int divisor;
    int r;
    delta = int'(sample) - int'(avg);
    divisor = (cnt == '0) ? 1 : int'(cnt);
    r = int'(avg) + delta / divisor;
    if (r < 0) r = 0;
    if (r > 255) r = 255;
    return r[SAMPLE_W-1:0];
  endfunction

  // Apply one packet to the shadow table and return the result it causes.
  function automatic nbr_update_t update_neighbour(input logic [ADDR_W-1:0] addr,
                                                   input logic [SAMPLE_W-1:0] rssi,
                                                   input logic [SAMPLE_W-1:0] lqi,
                                                   input logic [TIME_W-1:0] arrival);
    int slot;
    bit found;
    bit have_free;
    nbr_update_t res;
    slot = 0;
    found = 1'b0;
    have_free = 1'b0;
    res = '0;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (!found && nbr_valid[i] && nbr_addr[i] == addr) begin
        slot = i;
        found = 1'b1;
      end
    end
    if (found) begin
      nbr_pkt_cnt[slot] = (nbr_pkt_cnt[slot] >= pkt_win) ? 8'd1 : nbr_pkt_cnt[slot] + 8'd1;
      if (nbr_rssi_cnt[slot] >= rssi_win) begin
        nbr_rssi_cnt[slot] = 8'd1;
        nbr_rssi_avg[slot] = rssi;
      end else begin
        nbr_rssi_cnt[slot] = nbr_rssi_cnt[slot] + 8'd1;
        nbr_rssi_avg[slot] = average_step(nbr_rssi_avg[slot], rssi, nbr_rssi_cnt[slot]);
      end
      if (nbr_lqi_cnt[slot] >= lqi_win) begin
        nbr_lqi_cnt[slot] = 8'd1;
        nbr_lqi_avg[slot] = lqi;
      end else begin
        nbr_lqi_cnt[slot] = nbr_lqi_cnt[slot] + 8'd1;
        nbr_lqi_avg[slot] = average_step(nbr_lqi_avg[slot], lqi, nbr_lqi_cnt[slot]);
      end
      nbr_heard[slot] = arrival;
    end else begin
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        if (!have_free && !nbr_valid[i]) begin
          slot = i;
          have_free = 1'b1;
        end
      end
      // A full table gives up its least recently heard entry, lowest index on a tie.
      if (!have_free) begin
        slot = 0;
        for (int i = 1; i < TABLE_ENTRIES; i++) begin
          if (nbr_heard[i] < nbr_heard[slot]) slot = i;
        end
        res.evicted = 1'b1;
        res.evicted_addr = nbr_addr[slot];
      end
      nbr_valid[slot] = 1'b1;
      nbr_addr[slot] = addr;
      nbr_rssi_avg[slot] = rssi;
      nbr_lqi_avg[slot] = lqi;
      nbr_pkt_cnt[slot] = 8'd1;
      nbr_rssi_cnt[slot] = 8'd1;
      nbr_lqi_cnt[slot] = 8'd1;
      nbr_heard[slot] = arrival;
    end
    res.addr = nbr_addr[slot];
    res.rssi = nbr_rssi_avg[slot];
    res.lqi = nbr_lqi_avg[slot];
    res.pkt_count = nbr_pkt_cnt[slot];
    res.known = found;
    return res;
  endfunction

  // Random field values, with the extremes drawn often.
  function automatic logic [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return SAMPLE_W'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [ADDR_W-1:0] pick_address();
    if (hot_on && $urandom_range(0, 9) != 0) return hot_addr;
    if ($urandom_range(0, 19) == 0) return ADDR_W'($urandom);
    return addr_pool[$urandom_range(0, POOL_SIZE - 1)];
  endfunction

  // Mostly rising time with small steps; now and then a repeat or a jump anywhere.
  function automatic logic [TIME_W-1:0] next_tick();
    case ($urandom_range(0, 29))
      0: tick = TIME_W'($urandom);
      1: tick = tick;
      default: tick = tick + TIME_W'($urandom_range(1, 1000));
    endcase
    return tick;
  endfunction

  // Offer one item and hold it until the block takes it.
  task automatic send_packet(input logic [ADDR_W-1:0] addr,
                             input logic [SAMPLE_W-1:0] rssi,
                             input logic [SAMPLE_W-1:0] lqi,
                             input logic [TIME_W-1:0] arrival,
                             input logic pinned,
                             input nbr_update_t want);
    nbr_update_t predicted;
    in_sender_address <= addr;
    in_rssi_sample <= rssi;
    in_lqi_sample <= lqi;
    in_arrival_time <= arrival;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    predicted = update_neighbour(addr, rssi, lqi, arrival);
    pending_updates.push_back(pinned ? want : predicted);
  endtask

  task automatic hold_off(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Stop sending until every result is in and the block is idle.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending_updates.size() != 0 || busy) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // Write all three windows, then a write to the unused index.
  task automatic program_windows(input logic [COUNT_W-1:0] pw,
                                 input logic [COUNT_W-1:0] rw,
                                 input logic [COUNT_W-1:0] lw);
    cfg_we <= 1'b1;
    cfg_index <= nlq_pkg::CFG_PACKET_WINDOW;
    cfg_data <= pw;
    @(posedge clk);
    pkt_win = pw;
    cfg_index <= nlq_pkg::CFG_RSSI_WINDOW;
    cfg_data <= rw;
    @(posedge clk);
    rssi_win = rw;
    cfg_index <= nlq_pkg::CFG_LQI_WINDOW;
    cfg_data <= lw;
    @(posedge clk);
    lqi_win = lw;
    cfg_index <= CFG_UNUSED_INDEX;
    cfg_data <= CFG_DATA_W'($urandom);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h, actual %0h", $time, name, want, got);
      fail_count++;
    end
  endtask

  // Every strobed result is matched against the oldest outstanding expectation.
  always @(posedge clk) begin
    nbr_update_t want;
    if (rst_n && out_valid) begin
      if (pending_updates.size() == 0) begin
        $display("%0t: result for neighbour %0h with nothing outstanding", $time,
                 out_neighbor_address);
        fail_count++;
      end else begin
        want = pending_updates.pop_front();
        check_field("neighbor_address", 32'(want.addr), 32'(out_neighbor_address));
        check_field("rssi_average", 32'(want.rssi), 32'(out_rssi_average));
        check_field("lqi_average", 32'(want.lqi), 32'(out_lqi_average));
        check_field("packet_count", 32'(want.pkt_count), 32'(out_packet_count));
        check_field("was_known", 32'(want.known), 32'(out_was_known));
        check_field("did_evict", 32'(want.evicted), 32'(out_did_evict));
        check_field("evicted_address", 32'(want.evicted_addr), 32'(out_evicted_address));
      end
    end
  end

  // Stimulus: directed rows, then random phases, each with its own windows.
  initial begin
    int burst_left;
    int n_items;
    bit gaps_on;
    logic [COUNT_W-1:0] pw;
    logic [COUNT_W-1:0] rw;
    logic [COUNT_W-1:0] lw;
    rst_n <= 1'b0;
    start <= 1'b0;
    in_sender_address <= '0;
    in_rssi_sample <= '0;
    in_lqi_sample <= '0;
    in_arrival_time <= '0;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    pkt_win = nlq_pkg::WINDOW_RESET;
    rssi_win = nlq_pkg::WINDOW_RESET;
    lqi_win = nlq_pkg::WINDOW_RESET;
    for (int i = 0; i < TABLE_ENTRIES; i++) nbr_valid[i] = 1'b0;
    tick = '0;
    hot_on = 1'b0;
    hot_addr = '0;
    burst_left = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      send_packet(directed_rows[i].addr, directed_rows[i].rssi, directed_rows[i].lqi,
                  directed_rows[i].arrival, directed_rows[i].pinned, directed_rows[i].want);
    end
    drain();

    for (int phase = 0; phase < 6; phase++) begin
      gaps_on = 1'b1;
      hot_on = 1'b0;
      case (phase)
        0: begin
          // Windows of one restart every count; sent back to back.
          pw = 8'd1; rw = 8'd1; lw = 8'd1; n_items = 140; gaps_on = 1'b0;
        end
        1: begin
          // Widest windows, one busy neighbour, so its count reaches 255.
          pw = 8'd255; rw = 8'd255; lw = 8'd255; n_items = 300; hot_on = 1'b1;
        end
        2: begin
          // A window of zero restarts on every packet.
          pw = 8'd0; rw = 8'd0; lw = 8'd0; n_items = 80;
        end
        3: begin
          pw = COUNT_W'($urandom_range(2, 20));
          rw = COUNT_W'($urandom_range(2, 20));
          lw = COUNT_W'($urandom_range(2, 20));
          n_items = 240;
        end
        4: begin
          pw = 8'd200; rw = 8'd200; lw = 8'd200; n_items = 100; hot_on = 1'b1;
        end
        default: begin
          // Windows lowered below the counts built up in the phase before.
          pw = 8'd3; rw = 8'd9; lw = 8'd5; n_items = 120; hot_on = 1'b1;
        end
      endcase
      program_windows(pw, rw, lw);
      for (int i = 0; i < POOL_SIZE; i++) addr_pool[i] = ADDR_W'($urandom);
      hot_addr = ADDR_W'($urandom);
      for (int n = 0; n < n_items; n++) begin
        if (burst_left == 0) begin
          if (gaps_on) hold_off($urandom_range(1, 40));
          burst_left = $urandom_range(1, 8);
        end
        if ($urandom_range(0, 99) == 0) drain();
        send_packet(pick_address(), pick_sample(), pick_sample(), next_tick(), 1'b0, '0);
        burst_left--;
      end
      drain();
    end

    repeat (TABLE_ENTRIES + 30) @(posedge clk);
    if (pending_updates.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, pending_updates.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("neighbor_link_quality_table_tb OK");
    end else begin
      $display("neighbor_link_quality_table_tb NOT OK");
    end
    $finish;
  end

  // Hard stop well beyond the slowest correct run.
  initial begin
    #8_000_000;
    $display("neighbor_link_quality_table_tb NOT OK");
    $finish;
  end

endmodule

>>> files.f
hw/rtl/nlq_pkg.sv
hw/rtl/nlq_ram.sv
hw/rtl/nlq_div.sv
hw/rtl/neighbor_link_quality_table.sv
tb/neighbor_link_quality_table_tb.sv
